@@ hw/rtl/countdown_timer_display_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Countdown timer display controller: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_DISPLAY_CONTROLLER_MACROS_SVH
`define COUNTDOWN_TIMER_DISPLAY_CONTROLLER_MACROS_SVH

// Same-cycle implication
`define CTDC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CTDC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ctdc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctdc_pkg
// Types and constants of the countdown timer display controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ctdc_pkg;

  // Tick counter and divider widths
  localparam int TICK_W = 10;
  localparam int DIV_W  = 7;
  localparam int CNT_W  = $clog2(TICK_W);

  localparam logic [DIV_W-1:0] DIV_RESET = 7'd100;
  localparam logic [DIV_W-1:0] DIV_MIN   = 7'd1;

  // Display constants
  localparam logic [7:0] ALL_DIGITS = 8'h3C;
  localparam logic [7:0] RUN_POINT  = 8'h10;
  localparam logic [7:0] SEG_DP_OFF = 8'h80;

  // Active-low segment codes a..g for hex digits
  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78,
    8'h00, 8'h10, 8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E
  };

  // Operating mode
  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_RUN    = 3'd1,
    MODE_SET_MT = 3'd2,
    MODE_SET_MU = 3'd3,
    MODE_SET_ST = 3'd4,
    MODE_SET_SU = 3'd5
  } mode_t;

  // Divider request / response
  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TICK_W-1:0] quot;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ctdc_if.sv @@
// ----------------------------------------------------------------------------
// ctdc_if
// Valid/ready channels: button beats in, display beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctdc_in_if;
  logic valid;
  logic ready;
  logic up_button;
  logic down_button;
  logic set_button;
  logic start_button;

  modport source (output valid, up_button, down_button, set_button, start_button,
                  input ready);
  modport sink   (input valid, up_button, down_button, set_button, start_button,
                  output ready);
endinterface

interface ctdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] anode_select_n;
  logic [7:0] segment_pattern;
  logic       timer_is_zero;
  logic [2:0] run_mode;

  modport source (output valid, anode_select_n, segment_pattern, timer_is_zero, run_mode,
                  input ready);
  modport sink   (input valid, anode_select_n, segment_pattern, timer_is_zero, run_mode,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ctdc_divmod.sv @@
// ----------------------------------------------------------------------------
// ctdc_divmod
// Restoring divider, one quotient bit per cycle; splits the tick count into
// quotient and remainder by the base divider after a divider write.
// ----------------------------------------------------------------------------
`default_nettype none

module ctdc_divmod import ctdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  divisor_r;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;
  logic              fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem_r, quo_r[TICK_W-1]};
    trial    = shifted - {1'b0, divisor_r};
    fits     = (shifted >= {1'b0, divisor_r});
    rem_nxt  = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    quo_nxt  = {quo_r[TICK_W-2:0], fits};
    busy_nxt = busy_r;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
    end
    done_nxt = !req.start && busy_r && (cnt_r == '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (req.start) begin
        cnt_r <= CNT_W'(TICK_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor_r <= req.divisor;
      rem_r     <= '0;
      quo_r     <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

@@ hw/rtl/countdown_timer_display_controller.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_display_controller
// mm:ss countdown timer driving an eight-digit multiplexed seven-segment
// display, with stop / run / set-digit modes and button edge detection.
//
//   channel | dir | payload                                              | handshake
//   in_if   | in  | up_button, down_button, set_button, start_button     | valid/ready
//   out_if  | out | anode_select_n, segment_pattern, timer_is_zero,      | valid/ready
//           |     | run_mode                                             |
//   cfg_    | in  | cfg_data (base_divider, 7 bit)                       | cfg_we
//
// One beat in per cycle while in_if.ready is high; its result is registered in the output register.
// The tick counter is kept as quotient and remainder by the base divider, so
// every rate check is a compare; a divider write reloads them through the
// restoring divider: input held off from the write through the divider's done pulse.
// Reset is synchronous; no clearing pass. A stalled output holds its beat and
// blocks the next input beat only while the output register stays full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_timer_display_controller_macros.svh"

module countdown_timer_display_controller import ctdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ctdc_in_if.sink          in_if,
  ctdc_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [DIV_W-1:0] cfg_data
);

  // State
  logic [DIV_W-1:0]  p_r;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0] quo_r, quo_nxt;
  mode_t             mode_r, mode_nxt;
  logic [3:0]        sdf_r, sdf_nxt;
  logic [7:0]        den_r, den_nxt;
  logic [7:0]        pem_r, pem_nxt;
  logic              bf_r, bf_nxt;
  logic              bs_r, bs_nxt;
  logic [2:0]        mt_r, mt_nxt;
  logic [3:0]        mu_r, mu_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [3:0]        su_r, su_nxt;
  logic [2:0]        scan_r, scan_nxt;
  logic              set_prev_r, set_prev_nxt;
  logic              start_prev_r, start_prev_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        an_n_r, an_n_nxt;
  logic [7:0]        seg_r, seg_nxt;
  logic              zero_r, zero_nxt;
  logic [2:0]        run_mode_r;

  // Misc
  logic              in_fire;
  logic              in_rdy;
  logic [DIV_W-1:0]  cfg_div;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [7:0]        an;
  logic [3:0]        digit;
  logic              zero_old;
  logic              start_rise;
  logic              set_rise;
  logic              borrow;

  // Divider write: zero stores one
  assign cfg_div = (cfg_data == '0) ? DIV_MIN : cfg_data;

  assign div_req.start    = cfg_we;
  assign div_req.dividend = tick_r;
  assign div_req.divisor  = cfg_div;

  ctdc_divmod u_divmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Handshake
  assign in_rdy      = !cfg_we && !div_rsp.busy && !div_rsp.done &&
                       (!out_valid_r || out_if.ready);
  assign in_if.ready = in_rdy;
  assign in_fire     = in_if.valid && in_rdy;

  // Per-tick update
  always_comb begin
    tick_nxt       = tick_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    mode_nxt       = mode_r;
    sdf_nxt        = sdf_r;
    den_nxt        = den_r;
    pem_nxt        = pem_r;
    bf_nxt         = bf_r;
    bs_nxt         = bs_r;
    mt_nxt         = mt_r;
    mu_nxt         = mu_r;
    st_nxt         = st_r;
    su_nxt         = su_r;
    set_prev_nxt   = set_prev_r;
    start_prev_nxt = start_prev_r;
    start_rise     = !start_prev_r && in_if.start_button;
    set_rise       = !set_prev_r && in_if.set_button;
    borrow         = 1'b0;

    // Display refresh from pre-tick state
    an = (8'b1 << scan_r) & den_r;
    case (scan_r)
      3'd2:    digit = su_r;
      3'd3:    digit = {1'b0, st_r};
      3'd4:    digit = mu_r;
      3'd5:    digit = {1'b0, mt_r};
      default: digit = 4'd0;
    endcase
    seg_nxt = SEG_TABLE[digit];
    if ((an & pem_r) == 8'h00) begin
      seg_nxt = seg_nxt | SEG_DP_OFF;
    end
    an_n_nxt = ~an;
    scan_nxt = scan_r + 3'd1;

    zero_old = (mt_r == 3'd0) && (mu_r == 4'd0) && (st_r == 3'd0) && (su_r == 4'd0);

    // Tick counter as quotient / remainder
    tick_nxt = tick_r + TICK_W'(1);
    if (tick_nxt == '0) begin
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (({1'b0, rem_r} + 8'd1) == {1'b0, p_r}) begin
      rem_nxt = '0;
      quo_nxt = quo_r + TICK_W'(1);
    end else begin
      rem_nxt = rem_r + DIV_W'(1);
    end

    if (rem_nxt == '0) begin
      // Mode machine step
      unique case (mode_r)
        MODE_STOP: begin
          sdf_nxt        = 4'h0;
          start_prev_nxt = in_if.start_button;
          if (start_rise && !zero_old) begin
            mode_nxt = MODE_RUN;
          end else begin
            set_prev_nxt = in_if.set_button;
            if (set_rise) mode_nxt = MODE_SET_MT;
          end
        end
        MODE_RUN: begin
          sdf_nxt        = 4'h0;
          start_prev_nxt = in_if.start_button;
          if (start_rise || zero_old) begin
            mode_nxt = MODE_STOP;
          end else begin
            set_prev_nxt = in_if.set_button;
            if (set_rise) mode_nxt = MODE_SET_MT;
          end
        end
        MODE_SET_MT: begin
          sdf_nxt      = 4'h8;
          set_prev_nxt = in_if.set_button;
          if (set_rise) mode_nxt = MODE_SET_MU;
        end
        MODE_SET_MU: begin
          sdf_nxt      = 4'h4;
          set_prev_nxt = in_if.set_button;
          if (set_rise) mode_nxt = MODE_SET_ST;
        end
        MODE_SET_ST: begin
          sdf_nxt      = 4'h2;
          set_prev_nxt = in_if.set_button;
          if (set_rise) mode_nxt = MODE_SET_SU;
        end
        MODE_SET_SU: begin
          sdf_nxt      = 4'h1;
          set_prev_nxt = in_if.set_button;
          if (set_rise) mode_nxt = MODE_STOP;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase

      // Blank the digit being set on the off phase of the fast blink
      if ((sdf_nxt == 4'h0) || bf_r) begin
        den_nxt = ALL_DIGITS;
      end else begin
        den_nxt = ~({4'h0, sdf_nxt} << 2) & ALL_DIGITS;
      end

      if (!quo_nxt[0]) begin
        bf_nxt = !bf_r;
        if (quo_nxt[1:0] == 2'b00) begin
          bs_nxt = !bs_r;
          if (mode_nxt == MODE_RUN) begin
            pem_nxt = bs_nxt ? 8'h00 : RUN_POINT;
          end

          // Digit adjust, up wins over down
          case (mode_nxt)
            MODE_SET_MT: begin
              if (in_if.up_button)        mt_nxt = (mt_r < 3'd5) ? mt_r + 3'd1 : 3'd0;
              else if (in_if.down_button) mt_nxt = (mt_r > 3'd0) ? mt_r - 3'd1 : 3'd5;
            end
            MODE_SET_MU: begin
              if (in_if.up_button)        mu_nxt = (mu_r < 4'd9) ? mu_r + 4'd1 : 4'd0;
              else if (in_if.down_button) mu_nxt = (mu_r > 4'd0) ? mu_r - 4'd1 : 4'd9;
            end
            MODE_SET_ST: begin
              if (in_if.up_button)        st_nxt = (st_r < 3'd5) ? st_r + 3'd1 : 3'd0;
              else if (in_if.down_button) st_nxt = (st_r > 3'd0) ? st_r - 3'd1 : 3'd5;
            end
            MODE_SET_SU: begin
              if (in_if.up_button)        su_nxt = (su_r < 4'd9) ? su_r + 4'd1 : 4'd0;
              else if (in_if.down_button) su_nxt = (su_r > 4'd0) ? su_r - 4'd1 : 4'd9;
            end
            default: begin
              mt_nxt = mt_r;
            end
          endcase

          // Full period: one-second BCD countdown, counter restarts
          if (quo_nxt == TICK_W'(8)) begin
            if (mode_nxt == MODE_RUN) begin
              borrow = (su_r == 4'd0);
              su_nxt = borrow ? 4'd9 : su_r - 4'd1;
              if (borrow) begin
                borrow = (st_r == 3'd0);
                st_nxt = borrow ? 3'd5 : st_r - 3'd1;
                if (borrow) begin
                  borrow = (mu_r == 4'd0);
                  mu_nxt = borrow ? 4'd9 : mu_r - 4'd1;
                  if (borrow) begin
                    mt_nxt = (mt_r == 3'd0) ? 3'd5 : mt_r - 3'd1;
                  end
                end
              end
            end
            tick_nxt = '0;
            rem_nxt  = '0;
            quo_nxt  = '0;
          end
        end
      end
    end

    zero_nxt = (mt_nxt == 3'd0) && (mu_nxt == 4'd0) && (st_nxt == 3'd0) &&
               (su_nxt == 4'd0);

    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r          <= DIV_RESET;
      tick_r       <= '0;
      rem_r        <= '0;
      quo_r        <= '0;
      mode_r       <= MODE_STOP;
      sdf_r        <= 4'h0;
      den_r        <= ALL_DIGITS;
      pem_r        <= 8'h00;
      bf_r         <= 1'b0;
      bs_r         <= 1'b0;
      mt_r         <= 3'd5;
      mu_r         <= 4'd9;
      st_r         <= 3'd5;
      su_r         <= 4'd9;
      scan_r       <= 3'd0;
      set_prev_r   <= 1'b0;
      start_prev_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        p_r <= cfg_div;
      end
      if (div_rsp.done) begin
        rem_r <= div_rsp.rem;
        quo_r <= div_rsp.quot;
      end else if (in_fire) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
      end
      if (in_fire) begin
        tick_r       <= tick_nxt;
        mode_r       <= mode_nxt;
        sdf_r        <= sdf_nxt;
        den_r        <= den_nxt;
        pem_r        <= pem_nxt;
        bf_r         <= bf_nxt;
        bs_r         <= bs_nxt;
        mt_r         <= mt_nxt;
        mu_r         <= mu_nxt;
        st_r         <= st_nxt;
        su_r         <= su_nxt;
        scan_r       <= scan_nxt;
        set_prev_r   <= set_prev_nxt;
        start_prev_r <= start_prev_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      an_n_r     <= an_n_nxt;
      seg_r      <= seg_nxt;
      zero_r     <= zero_nxt;
      run_mode_r <= mode_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.anode_select_n  = an_n_r;
  assign out_if.segment_pattern = seg_r;
  assign out_if.timer_is_zero   = zero_r;
  assign out_if.run_mode        = run_mode_r;

  // Checks
  `CTDC_ASSERT_NOW(a_rem_below_div, clk, rst_n, in_fire, rem_r < p_r, "tick remainder not below divider")
  `CTDC_ASSERT_NEXT(a_beat_lands, clk, rst_n, in_fire, out_valid_r, "accepted beat produced no result")
  `CTDC_ASSERT_NOW(a_run_no_set, clk, rst_n, mode_r == MODE_RUN, sdf_r == 4'h0, "set flags active while running")
  `CTDC_ASSERT_NOW(a_bcd_units, clk, rst_n, 1'b1, (mu_r <= 4'd9) && (su_r <= 4'd9), "units digit out of BCD range")

endmodule

`default_nettype wire
